[rtl/least_loaded_slot_allocator_assert.svh]
// assertion helpers for the slot allocator, clocked on clk, off during rst
`ifndef LEAST_LOADED_SLOT_ALLOCATOR_ASSERT_SVH
`define LEAST_LOADED_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define LLSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/llsa_pkg.sv]
// ----------------------------------------------------------------------------
// llsa_pkg
// Shared codes, state type and controller/datapath interface structs for the
// least-loaded slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package llsa_pkg;

  // request kinds
  localparam logic [2:0] REQ_ALLOC     = 3'd0;
  localparam logic [2:0] REQ_RELEASE   = 3'd1;
  localparam logic [2:0] REQ_ADD       = 3'd2;
  localparam logic [2:0] REQ_REMOVE    = 3'd3;
  localparam logic [2:0] REQ_HEARTBEAT = 3'd4;

  // result status
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_SERVER = 3'd1;
  localparam logic [2:0] STAT_NO_SLOT   = 3'd2;
  localparam logic [2:0] STAT_MISMATCH  = 3'd3;
  localparam logic [2:0] STAT_BAD_ID    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIND,
    S_RESP
  } llsa_state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic find_step;
    logic commit;
  } llsa_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_last;
    logic best_found;
    logic slot_hit;
    logic chunk_last;
    logic out_free;
  } llsa_sts_t;

endpackage

`default_nettype wire

[rtl/llsa_ctrl.sv]
// ----------------------------------------------------------------------------
// llsa_ctrl
// Request sequencer: accept, server scan, free-slot search, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module llsa_ctrl
  import llsa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire llsa_sts_t sts,
  output llsa_cmd_t      cmd
);

  llsa_state_t state;
  llsa_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // non-alloc requests go straight to commit
        if (!sts.is_alloc) begin
          state_next = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_last) begin
            state_next = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (!sts.best_found) begin
          state_next = S_RESP;
        end else begin
          cmd.find_step = 1'b1;
          if (sts.slot_hit || sts.chunk_last) begin
            state_next = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/llsa_datapath.sv]
// ----------------------------------------------------------------------------
// llsa_datapath
// Server table, request context, min-count scan, chunked free-slot search
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "least_loaded_slot_allocator_assert.svh"

module llsa_datapath
  import llsa_pkg::*;
#(
  parameter int NUM_SERVERS      = 8,
  parameter int SLOTS_PER_SERVER = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] server_id,
  input  wire logic [4:0]  slot_index,
  input  wire logic [31:0] ip_addr,
  input  wire logic [15:0] port_num,
  input  wire logic [31:0] now_time,
  input  wire llsa_cmd_t   cmd,
  output llsa_sts_t        sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             ok,
  output logic [2:0]       status,
  output logic [2:0]       granted_server,
  output logic [4:0]       granted_slot,
  output logic [31:0]      granted_ip,
  output logic [15:0]      granted_port
);

  localparam int IDX_W   = $clog2(NUM_SERVERS);
  localparam int SLOT_W  = $clog2(SLOTS_PER_SERVER);
  localparam int CNT_W   = $clog2(SLOTS_PER_SERVER + 1);
  localparam int ADDR_W  = IDX_W + SLOT_W;
  localparam int SCAN_W  = 8;
  localparam int SEL_W   = $clog2(SCAN_W);
  localparam int NCHUNK  = (SLOTS_PER_SERVER + SCAN_W - 1) / SCAN_W;
  localparam int CH_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W   = NCHUNK * SCAN_W;

  // configuration
  logic [15:0] server_id_base;

  // request context
  logic [2:0]       req_q;
  logic [IDX_W-1:0] sidx_q;
  logic             bad_q;
  logic [4:0]       slot_q;
  logic [31:0]      ip_q;
  logic [15:0]      port_q;
  logic [31:0]      now_q;

  // server table
  logic [NUM_SERVERS-1:0]      online;
  logic [CNT_W-1:0]            conn_count     [NUM_SERVERS];
  logic [SLOTS_PER_SERVER-1:0] slot_used      [NUM_SERVERS];
  logic [31:0]                 server_ip      [NUM_SERVERS];
  logic [15:0]                 server_port    [NUM_SERVERS];
  logic [31:0]                 heartbeat_time [NUM_SERVERS];
  logic [31:0]                 slot_stamp     [2**ADDR_W];

  // search state
  logic [IDX_W-1:0]  scan_idx;
  logic [IDX_W-1:0]  best;
  logic [CNT_W-1:0]  best_count;
  logic              found;
  logic [CH_W-1:0]   chunk;
  logic              slot_hit_q;
  logic [SLOT_W-1:0] slot_sel;

  // shared table read port
  logic [IDX_W-1:0]            rd_idx;
  logic                        rd_online;
  logic [CNT_W-1:0]            rd_count;
  logic [SLOTS_PER_SERVER-1:0] rd_used;
  logic [31:0]                 rd_ip;
  logic [15:0]                 rd_port;
  logic                        addr_match;

  logic [15:0]       sdiff;
  logic [PAD_W-1:0]  padded;
  logic [SCAN_W-1:0] free_bits;
  logic              chunk_hit;
  logic [SEL_W-1:0]  free_sel;
  logic [SLOT_W-1:0] rel_bit;

  logic       res_ok;
  logic [2:0] res_st;
  logic       do_alloc;
  logic       do_release;
  logic       do_add;
  logic       do_remove;
  logic       do_hb;

  assign sdiff   = server_id - server_id_base;
  assign rel_bit = SLOT_W'(slot_q);

  always_comb begin
    if (cmd.scan_step) begin
      rd_idx = scan_idx;
    end else if (req_q == REQ_ALLOC) begin
      rd_idx = best;
    end else begin
      rd_idx = sidx_q;
    end
  end

  assign rd_online  = online[rd_idx];
  assign rd_count   = conn_count[rd_idx];
  assign rd_used    = slot_used[rd_idx];
  assign rd_ip      = server_ip[rd_idx];
  assign rd_port    = server_port[rd_idx];
  assign addr_match = (rd_ip == ip_q) && (rd_port == port_q);

  // slot map padded with used bits past the last real slot
  always_comb begin
    padded                         = '1;
    padded[SLOTS_PER_SERVER-1:0]   = rd_used;
    free_bits                      = ~padded[int'(chunk) * SCAN_W +: SCAN_W];
    chunk_hit                      = |free_bits;
    free_sel                       = '0;
    for (int b = SCAN_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_sel = SEL_W'(b);
      end
    end
  end

  always_comb begin
    sts.is_alloc   = (req_q == REQ_ALLOC);
    sts.scan_last  = (scan_idx == IDX_W'(NUM_SERVERS - 1));
    sts.best_found = found;
    sts.slot_hit   = chunk_hit;
    sts.chunk_last = (chunk == CH_W'(NCHUNK - 1));
    sts.out_free   = !out_valid || out_ready;
  end

  // result and table action for the pending request
  always_comb begin
    res_ok     = 1'b0;
    res_st     = STAT_BAD_ID;
    do_alloc   = 1'b0;
    do_release = 1'b0;
    do_add     = 1'b0;
    do_remove  = 1'b0;
    do_hb      = 1'b0;
    if (req_q == REQ_ALLOC) begin
      if (!found) begin
        res_st = STAT_NO_SERVER;
      end else if (!slot_hit_q) begin
        res_st = STAT_NO_SLOT;
      end else begin
        res_ok   = 1'b1;
        res_st   = STAT_OK;
        do_alloc = 1'b1;
      end
    end else if (!bad_q) begin
      unique case (req_q)
        REQ_RELEASE: begin
          if (int'(slot_q) < SLOTS_PER_SERVER) begin
            res_ok     = 1'b1;
            res_st     = STAT_OK;
            do_release = 1'b1;
          end
        end
        REQ_ADD: begin
          if (rd_online && !addr_match) begin
            res_st = STAT_MISMATCH;
          end else begin
            res_ok = 1'b1;
            res_st = STAT_OK;
            do_add = 1'b1;
          end
        end
        REQ_REMOVE: begin
          res_ok    = 1'b1;
          res_st    = STAT_OK;
          do_remove = 1'b1;
        end
        REQ_HEARTBEAT: begin
          if (!rd_online) begin
            res_st = STAT_BAD_ID;
          end else if (!addr_match) begin
            res_st = STAT_MISMATCH;
          end else begin
            res_ok = 1'b1;
            res_st = STAT_OK;
            do_hb  = 1'b1;
          end
        end
        default: begin
          res_st = STAT_BAD_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_id_base <= '0;
    end else if (cfg_wr_en) begin
      server_id_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req_type;
      sidx_q     <= sdiff[IDX_W-1:0];
      bad_q      <= (sdiff >= 16'(NUM_SERVERS));
      slot_q     <= slot_index;
      ip_q       <= ip_addr;
      port_q     <= port_num;
      now_q      <= now_time;
      scan_idx   <= '0;
      best       <= '0;
      best_count <= CNT_W'(SLOTS_PER_SERVER);
      chunk      <= '0;
      slot_sel   <= '0;
    end else begin
      if (cmd.scan_step) begin
        if (rd_online && (rd_count < best_count)) begin
          best       <= scan_idx;
          best_count <= rd_count;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.find_step) begin
        if (chunk_hit) begin
          slot_sel <= SLOT_W'({chunk, free_sel});
        end
        chunk <= chunk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      slot_hit_q <= 1'b0;
    end else if (cmd.load) begin
      found      <= 1'b0;
      slot_hit_q <= 1'b0;
    end else begin
      if (cmd.scan_step && rd_online && (rd_count < best_count)) begin
        found <= 1'b1;
      end
      if (cmd.find_step && chunk_hit) begin
        slot_hit_q <= 1'b1;
      end
    end
  end

  // table entries that reset clears
  always_ff @(posedge clk) begin
    if (rst) begin
      online         <= '0;
      conn_count     <= '{default: '0};
      slot_used      <= '{default: '0};
      heartbeat_time <= '{default: '0};
    end else if (cmd.commit) begin
      if (do_alloc) begin
        slot_used[rd_idx][slot_sel] <= 1'b1;
        conn_count[rd_idx]          <= rd_count + 1'b1;
      end
      if (do_release) begin
        slot_used[rd_idx][rel_bit] <= 1'b0;
        if (rd_count != '0) begin
          conn_count[rd_idx] <= rd_count - 1'b1;
        end
      end
      if (do_add) begin
        online[rd_idx]     <= 1'b1;
        conn_count[rd_idx] <= '0;
      end
      if (do_remove) begin
        online[rd_idx]     <= 1'b0;
        conn_count[rd_idx] <= '0;
      end
      if (do_hb) begin
        heartbeat_time[rd_idx] <= now_q;
      end
    end
  end

  // address entries, valid only once an add has written them
  always_ff @(posedge clk) begin
    if (cmd.commit && do_add) begin
      server_ip[rd_idx]   <= ip_q;
      server_port[rd_idx] <= port_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_alloc) begin
      slot_stamp[{rd_idx, slot_sel}] <= now_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok     <= res_ok;
      status <= res_st;
      if (do_alloc) begin
        granted_server <= 3'(best);
        granted_slot   <= 5'(slot_sel);
        granted_ip     <= rd_ip;
        granted_port   <= rd_port;
      end else begin
        granted_server <= '0;
        granted_slot   <= '0;
        granted_ip     <= '0;
        granted_port   <= '0;
      end
    end
  end

  `LLSA_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid, "committed word not presented")
  `LLSA_ASSERT_SAME(a_best_below_limit, found, best_count < CNT_W'(SLOTS_PER_SERVER), "best count at limit")
  `LLSA_ASSERT_SAME(a_find_needs_server, cmd.find_step, found, "slot search without a chosen server")

endmodule

`default_nettype wire

[rtl/least_loaded_slot_allocator.sv]
// ----------------------------------------------------------------------------
// least_loaded_slot_allocator
// Least-connections server table with per-server slot maps.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Add, remove, heartbeat and
// release skip both searches. Alloc runs the lowest-count search, which
// reads one server entry per cycle over the shared table port, and, if a
// server is found, the free-slot search, which checks eight slot bits per
// cycle. One request is in flight at a time; the result register lets the
// next request be accepted while a result waits. Non-alloc requests with an
// id whose offset from server_id_base is past the table, or with an unknown
// kind, return status 4 and leave the table alone.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_slot_allocator
  import llsa_pkg::*;
#(
  parameter int NUM_SERVERS      = 8,
  parameter int SLOTS_PER_SERVER = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] server_id,
  input  wire logic [4:0]  slot_index,
  input  wire logic [31:0] ip_addr,
  input  wire logic [15:0] port_num,
  input  wire logic [31:0] now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [2:0]       status,
  output logic [2:0]       granted_server,
  output logic [4:0]       granted_slot,
  output logic [31:0]      granted_ip,
  output logic [15:0]      granted_port
);

  llsa_cmd_t cmd;
  llsa_sts_t sts;

  llsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  llsa_datapath #(
    .NUM_SERVERS      (NUM_SERVERS),
    .SLOTS_PER_SERVER (SLOTS_PER_SERVER)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .req_type       (req_type),
    .server_id      (server_id),
    .slot_index     (slot_index),
    .ip_addr        (ip_addr),
    .port_num       (port_num),
    .now_time       (now_time),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .ok             (ok),
    .status         (status),
    .granted_server (granted_server),
    .granted_slot   (granted_slot),
    .granted_ip     (granted_ip),
    .granted_port   (granted_port)
  );

endmodule

`default_nettype wire
